FILE: rtl/prq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the packet ring queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int DEF_SLOTS      = 16;
  localparam int DEF_SLOT_BYTES = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES  = 2'd1;

  localparam logic [CFG_W-1:0] RST_SLOT_COUNT = 5'd16;
  localparam logic [CFG_W-1:0] RST_MAX_BYTES  = 5'd16;

  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_RECV  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [6:0] ASM_SAT = 7'd127;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_LONG  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_SMALL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_RECV,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_STREAM
  } back_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [6:0] buffer_length;
  } req_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] byte_out;
    logic [4:0] length;
    logic       last;
  } rsp_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [6:0] buffer_length;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/packet_ring_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_ring_queue
// Ring of fixed-size packet slots with stored lengths; send, receive, query.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_item_t
//   rsp      out        rsp_valid/rsp_ready   rsp_item_t
//   cfg      in         cfg_we                cfg_index, cfg_data
//
// A receive or query on a non-empty ring reads the slot length in IDLE and
// decides in LOOK; a delivered packet then streams one byte per cycle, while
// rsp_ready allows, from the single read port of the packet memory. A
// two-item command queue keeps taking items until it is full while the back
// end stalls on rsp_ready. Synchronous reset clears indexes and counts and
// sets both config registers to 16; memories are not cleared.
// ----------------------------------------------------------------------------
module packet_ring_queue
  import prq_pkg::*;
#(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire req_item_t            req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output rsp_item_t                 rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  prq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  prq_back #(.SLOTS(SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

FILE: rtl/prq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/prq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_front
// Accepts request items, decodes the kind, queues known kinds (two deep).
// ----------------------------------------------------------------------------
module prq_front
  import prq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_item_t req,
  output logic           q_valid,
  output cmd_t           q_cmd,
  input  wire logic      q_pop
);

  cmd_t       ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       known;
  cmd_t       dec;
  logic       push;

  always_comb begin
    known             = 1'b1;
    dec.op            = OP_SEND;
    dec.data_byte     = req.data_byte;
    dec.last_byte     = req.last_byte;
    dec.buffer_length = req.buffer_length;
    case (req.kind)
      KIND_SEND:  dec.op = OP_SEND;
      KIND_RECV:  dec.op = OP_RECV;
      KIND_QUERY: dec.op = OP_QUERY;
      default:    known  = 1'b0;
    endcase
  end

  assign req_ready = (cnt != 2'd2);
  assign push      = req_valid && req_ready && known;
  assign q_valid   = (cnt != 2'd0);
  assign q_cmd     = ent[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/prq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_back
// Executes queued commands against the slot ring and drives the result register.
// ----------------------------------------------------------------------------
module prq_back
  import prq_pkg::*;
#(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire cmd_t                 q_cmd,
  output logic                      q_pop,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output rsp_item_t                 rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int IW  = $clog2(SLOTS);
  localparam int FW  = $clog2(SLOTS + 1);
  localparam int BAW = $clog2(SLOTS * SLOT_BYTES);

  back_state_t state, state_next;

  logic [IW-1:0]  write_slot, write_slot_next;
  logic [IW-1:0]  read_slot, read_slot_next;
  logic [FW-1:0]  fill, fill_next;
  logic [6:0]     asm_cnt, asm_cnt_next;
  logic           overlong, overlong_next;
  logic [CFG_W-1:0] slot_count;
  logic [CFG_W-1:0] max_bytes;
  logic [IW-1:0]  str_slot, str_slot_next;
  logic [4:0]     str_len, str_len_next;
  logic [4:0]     str_cnt, str_cnt_next;
  logic           rd_pend, rd_pend_next;
  logic           rd_last, rd_last_next;
  rsp_item_t      load_item;
  logic           load;

  logic [FW-1:0]  eff_slots;
  logic [6:0]     eff_max;
  logic           full;
  logic           ofree;
  logic [4:0]     head_len;
  logic           move;
  logic           issue;

  logic           byte_we, byte_re;
  logic [BAW-1:0] byte_waddr, byte_raddr;
  logic [7:0]     byte_rdata;
  logic           len_we, len_re;
  logic [4:0]     len_rdata;

  function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                            input logic [FW-1:0] lim);
    logic [FW:0] n;
    n = {1'b0, FW'(idx)} + 1'b1;
    if (n >= {1'b0, lim}) begin
      n = '0;
    end
    return IW'(n);
  endfunction

  function automatic logic [4:0] asm_cnt_next_commit();
    return 5'(asm_cnt + 7'd1);
  endfunction

  prq_ram #(.WIDTH(8), .DEPTH(SLOTS * SLOT_BYTES), .ADDR_W(BAW)) u_bytes (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (q_cmd.data_byte),
    .re    (byte_re),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  prq_ram #(.WIDTH(5), .DEPTH(SLOTS), .ADDR_W(IW)) u_lens (
    .clk   (clk),
    .we    (len_we),
    .waddr (write_slot),
    .wdata (asm_cnt_next_commit()),
    .re    (len_re),
    .raddr (read_slot),
    .rdata (len_rdata)
  );

  always_comb begin
    if (slot_count == '0) begin
      eff_slots = FW'(1);
    end else if (int'(slot_count) > SLOTS) begin
      eff_slots = FW'(SLOTS);
    end else begin
      eff_slots = FW'(slot_count);
    end
    eff_max  = (int'(max_bytes) > SLOT_BYTES) ? 7'(SLOT_BYTES) : 7'(max_bytes);
    head_len = (int'(len_rdata) > SLOT_BYTES) ? 5'(SLOT_BYTES) : len_rdata;
  end

  assign full       = (fill >= eff_slots);
  assign ofree      = !rsp_valid || rsp_ready;
  assign byte_waddr = BAW'(int'(write_slot) * SLOT_BYTES + int'(asm_cnt));
  assign byte_raddr = BAW'(int'(str_slot) * SLOT_BYTES + int'(str_cnt));

  always_comb begin
    state_next      = state;
    write_slot_next = write_slot;
    read_slot_next  = read_slot;
    fill_next       = fill;
    asm_cnt_next    = asm_cnt;
    overlong_next   = overlong;
    str_slot_next   = str_slot;
    str_len_next    = str_len;
    str_cnt_next    = str_cnt;
    rd_pend_next    = rd_pend;
    rd_last_next    = rd_last;
    q_pop           = 1'b0;
    load            = 1'b0;
    load_item       = '{status: ST_OK, byte_out: 8'd0, length: 5'd0, last: 1'b1};
    byte_we         = 1'b0;
    byte_re         = 1'b0;
    len_we          = 1'b0;
    len_re          = 1'b0;
    move            = 1'b0;
    issue           = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_SEND: begin
              if (!q_cmd.last_byte || ofree) begin
                q_pop = 1'b1;
                if (asm_cnt < eff_max) begin
                  byte_we = !full;
                end else begin
                  overlong_next = 1'b1;
                end
                if (asm_cnt != ASM_SAT) begin
                  asm_cnt_next = asm_cnt + 7'd1;
                end
                if (q_cmd.last_byte) begin
                  load = 1'b1;
                  if (full) begin
                    load_item.status = ST_FULL;
                  end else if (overlong_next) begin
                    load_item.status = ST_LONG;
                  end else begin
                    load_item.length = 5'(asm_cnt_next);
                    len_we           = 1'b1;
                    write_slot_next  = advance(write_slot, eff_slots);
                    fill_next        = fill + FW'(1);
                  end
                  asm_cnt_next  = '0;
                  overlong_next = 1'b0;
                end
              end
            end
            OP_RECV, OP_QUERY: begin
              if (fill == '0) begin
                if (ofree) begin
                  q_pop            = 1'b1;
                  load             = 1'b1;
                  load_item.status = ST_EMPTY;
                end
              end else begin
                len_re     = 1'b1;
                state_next = BK_LOOK;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_LOOK: begin
        if (ofree) begin
          q_pop      = 1'b1;
          state_next = BK_IDLE;
          load_item.length = head_len;
          if (q_cmd.op == OP_QUERY) begin
            load = 1'b1;
          end else if (q_cmd.buffer_length < 7'(head_len)) begin
            load             = 1'b1;
            load_item.status = ST_SMALL;
          end else begin
            read_slot_next = advance(read_slot, eff_slots);
            fill_next      = fill - FW'(1);
            if (head_len == 5'd0) begin
              load = 1'b1;
            end else begin
              str_slot_next = read_slot;
              str_len_next  = head_len;
              str_cnt_next  = 5'd0;
              state_next    = BK_STREAM;
            end
          end
        end
      end
      BK_STREAM: begin
        move  = rd_pend && ofree;
        issue = (str_cnt < str_len) && (!rd_pend || move);
        if (move) begin
          load               = 1'b1;
          load_item.byte_out = byte_rdata;
          load_item.length   = str_len;
          load_item.last     = rd_last;
        end
        if (issue) begin
          byte_re      = 1'b1;
          rd_last_next = (5'(str_cnt + 5'd1) == str_len);
          str_cnt_next = str_cnt + 5'd1;
        end
        rd_pend_next = issue || (rd_pend && !move);
        if (!issue && !rd_pend_next) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      write_slot <= '0;
      read_slot  <= '0;
      fill       <= '0;
      asm_cnt    <= '0;
      overlong   <= 1'b0;
      rd_pend    <= 1'b0;
      rsp_valid  <= 1'b0;
      slot_count <= RST_SLOT_COUNT;
      max_bytes  <= RST_MAX_BYTES;
    end else begin
      state      <= state_next;
      write_slot <= write_slot_next;
      read_slot  <= read_slot_next;
      fill       <= fill_next;
      asm_cnt    <= asm_cnt_next;
      overlong   <= overlong_next;
      rd_pend    <= rd_pend_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we && cfg_index == CFG_SLOT_COUNT) begin
        slot_count <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_MAX_BYTES) begin
        max_bytes <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    str_slot <= str_slot_next;
    str_len  <= str_len_next;
    str_cnt  <= str_cnt_next;
    rd_last  <= rd_last_next;
    if (load) begin
      rsp <= load_item;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= SLOTS)
    else $error("fill count above slot capacity");

  a_pend_stream: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == BK_STREAM)
    else $error("byte read pending outside stream");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");

  a_stream_cnt: assert property (@(posedge clk) disable iff (rst)
    state == BK_STREAM |-> str_cnt <= str_len && str_len != 5'd0)
    else $error("stream counter out of range");

endmodule
`default_nettype wire

FILE: bench/tb_packet_ring_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_ring_queue
// Self-checking bench for the packet ring queue. A short table of directed
// items comes first, then the ring is filled to full and drained under a long
// receiver hold. Random phases follow, each under a new slot count and length
// limit, with whole packets, receives, queries, stray fragments and ignored
// kinds. Every item is run through a ring model on acceptance, and each
// result is checked in order against the typed table entry or the model.
// ----------------------------------------------------------------------------
module tb_packet_ring_queue;
  import prq_pkg::*;

  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam int         CFG_SETTLE     = 20;
  localparam int         END_DRAIN      = 40;
  localparam int         RX_HOLD_CYCLES = 150;
  localparam int         IDLE_LIMIT     = 2000;
  localparam int         PHASE_ITEMS    = 6;
  localparam int         NUM_PHASES     = 4;

  typedef struct packed {
    req_item_t item;
    logic      typed;
    rsp_item_t want;
  } dir_row_t;

  localparam rsp_item_t NOT_TYPED = '{ST_OK, 8'h00, 5'd0, 1'b0};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid;
  logic      req_ready;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  packet_ring_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring model state
  logic [7:0]  pkt_mem [DEF_SLOTS][DEF_SLOT_BYTES];
  logic [4:0]  len_mem [DEF_SLOTS];
  int unsigned wr_idx, rd_idx, used, asm_cnt;
  bit          overlong;
  logic [4:0]  cfg_slots, cfg_max;

  rsp_item_t step_rsp [$];
  rsp_item_t rsp_due [$];
  rsp_item_t due_head;
  int        errors = 0;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit rx_hold_req = 1'b0;

  dir_row_t dir_rows [18] = '{
    '{'{KIND_RECV,   8'h00, 1'b0, 7'd0},  1'b1, '{ST_EMPTY, 8'h00, 5'd0, 1'b1}},
    '{'{KIND_QUERY,  8'h00, 1'b0, 7'd64}, 1'b1, '{ST_EMPTY, 8'h00, 5'd0, 1'b1}},
    '{'{KIND_UNUSED, 8'hff, 1'b1, 7'h7f}, 1'b0, NOT_TYPED},
    '{'{KIND_SEND,   8'hff, 1'b1, 7'd0},  1'b1, '{ST_OK,    8'h00, 5'd1, 1'b1}},
    '{'{KIND_QUERY,  8'h00, 1'b0, 7'd0},  1'b1, '{ST_OK,    8'h00, 5'd1, 1'b1}},
    '{'{KIND_RECV,   8'h00, 1'b0, 7'd0},  1'b1, '{ST_SMALL, 8'h00, 5'd1, 1'b1}},
    '{'{KIND_RECV,   8'h00, 1'b0, 7'd64}, 1'b1, '{ST_OK,    8'hff, 5'd1, 1'b1}},
    '{'{KIND_SEND,   8'h00, 1'b0, 7'h40}, 1'b0, NOT_TYPED},
    '{'{KIND_SEND,   8'h5a, 1'b0, 7'd0},  1'b0, NOT_TYPED},
    '{'{KIND_SEND,   8'ha5, 1'b1, 7'd0},  1'b0, NOT_TYPED},
    '{'{KIND_SEND,   8'h80, 1'b1, 7'd0},  1'b0, NOT_TYPED},
    '{'{KIND_RECV,   8'h00, 1'b0, 7'd2},  1'b0, NOT_TYPED},
    '{'{KIND_RECV,   8'hff, 1'b1, 7'd3},  1'b0, NOT_TYPED},
    '{'{KIND_QUERY,  8'h00, 1'b0, 7'd0},  1'b0, NOT_TYPED},
    '{'{KIND_RECV,   8'h00, 1'b0, 7'd64}, 1'b0, NOT_TYPED},
    '{'{KIND_RECV,   8'h00, 1'b0, 7'd64}, 1'b1, '{ST_EMPTY, 8'h00, 5'd0, 1'b1}},
    '{'{KIND_SEND,   8'h7f, 1'b1, 7'h3f}, 1'b0, NOT_TYPED},
    '{'{KIND_QUERY,  8'h00, 1'b0, 7'd0},  1'b0, NOT_TYPED}
  };

  logic [4:0] ph_slots [NUM_PHASES] = '{5'd4, 5'd0, 5'd31, 5'd2};
  logic [4:0] ph_max   [NUM_PHASES] = '{5'd5, 5'd0, 5'd31, 5'd3};

  function automatic int unsigned ring_slots();
    if (cfg_slots == 5'd0) return 1;
    if (cfg_slots > DEF_SLOTS) return DEF_SLOTS;
    return cfg_slots;
  endfunction

  function automatic int unsigned ring_max();
    if (cfg_max > DEF_SLOT_BYTES) return DEF_SLOT_BYTES;
    return cfg_max;
  endfunction

  function automatic int unsigned next_slot(input int unsigned idx);
    if (idx + 1 >= ring_slots()) return 0;
    return idx + 1;
  endfunction

  function automatic void add_rsp(input status_t st, input logic [7:0] b,
                                  input int unsigned l, input logic lst);
    rsp_item_t r;
    r.status   = st;
    r.byte_out = b;
    r.length   = 5'(l);
    r.last     = lst;
    step_rsp.push_back(r);
  endfunction

  function automatic req_item_t mk_req(input logic [1:0] k, input logic [7:0] d,
                                       input logic l, input logic [6:0] b);
    req_item_t r;
    r.kind          = k;
    r.data_byte     = d;
    r.last_byte     = l;
    r.buffer_length = b;
    return r;
  endfunction

  // one accepted item through the ring model; results land in step_rsp
  task automatic ring_step(input req_item_t it);
    int unsigned ws, rs, ln, i;
    bit full;
    step_rsp.delete();
    ws = wr_idx % DEF_SLOTS;
    rs = rd_idx % DEF_SLOTS;
    case (it.kind)
      KIND_SEND: begin
        full = (used >= ring_slots());
        if (asm_cnt < ring_max()) begin
          if (!full) pkt_mem[ws][asm_cnt] = it.data_byte;
        end else begin
          overlong = 1'b1;
        end
        if (asm_cnt < ASM_SAT) asm_cnt++;
        if (it.last_byte) begin
          if (full) begin
            add_rsp(ST_FULL, 8'h00, 0, 1'b1);
          end else if (overlong) begin
            add_rsp(ST_LONG, 8'h00, 0, 1'b1);
          end else begin
            len_mem[ws] = 5'(asm_cnt);
            add_rsp(ST_OK, 8'h00, asm_cnt, 1'b1);
            wr_idx = next_slot(ws);
            used++;
          end
          asm_cnt  = 0;
          overlong = 1'b0;
        end
      end
      KIND_RECV, KIND_QUERY: begin
        if (used == 0) begin
          add_rsp(ST_EMPTY, 8'h00, 0, 1'b1);
        end else begin
          ln = len_mem[rs];
          if (ln > DEF_SLOT_BYTES) ln = DEF_SLOT_BYTES;
          if (it.kind == KIND_QUERY) begin
            add_rsp(ST_OK, 8'h00, ln, 1'b1);
          end else if (it.buffer_length < ln) begin
            add_rsp(ST_SMALL, 8'h00, ln, 1'b1);
          end else begin
            rd_idx = next_slot(rs);
            used--;
            for (i = 0; i < ln; i++)
              add_rsp(ST_OK, pkt_mem[rs][i], ln, (i + 1 == ln));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_req(input req_item_t it, input logic typed, input rsp_item_t want);
    int gap;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (!req_ready);
    ring_step(it);
    if (typed) rsp_due.push_back(want);
    else foreach (step_rsp[i]) rsp_due.push_back(step_rsp[i]);
    if (tx_idle_en && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // with a packet queued, half the time the buffer is made to fit the head packet
  function automatic logic [6:0] pick_buflen();
    int unsigned h;
    if (used != 0 && $urandom_range(0, 1) == 1) begin
      h = len_mem[rd_idx % DEF_SLOTS];
      return 7'($urandom_range(h, 64));
    end
    return 7'($urandom_range(0, 64));
  endfunction

  function automatic int unsigned pick_len();
    int unsigned m;
    m = ring_max();
    if (m == 0) return $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, m + 2);
    return $urandom_range(1, (m < 4) ? m : 4);
  endfunction

  task automatic send_packet(input int unsigned nbytes);
    int unsigned k;
    for (k = 0; k < nbytes; k++) begin
      if (k != 0 && $urandom_range(0, 9) == 0)
        push_req(mk_req($urandom_range(0, 1) ? KIND_RECV : KIND_QUERY, 8'($urandom),
                        1'($urandom), pick_buflen()), 1'b0, NOT_TYPED);
      push_req(mk_req(KIND_SEND, 8'($urandom), (k + 1 == nbytes), 7'($urandom)),
               1'b0, NOT_TYPED);
    end
  endtask

  task automatic set_cfg(input logic [4:0] slots, input logic [4:0] maxb);
    @(negedge clk);
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLOT_COUNT;
    cfg_data  <= slots;
    @(negedge clk);
    cfg_index <= CFG_MAX_BYTES;
    cfg_data  <= maxb;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_slots = slots;
    cfg_max   = maxb;
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin : rx_side
    int n;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rsp_ready <= 1'b0;
        for (n = 0; n < RX_HOLD_CYCLES; n++) @(negedge clk);
        rx_hold_req = 1'b0;
        rsp_ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(negedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: status %0d byte %02h length %0d last %0d",
                 $time, rsp.status, rsp.byte_out, rsp.length, rsp.last);
      end else begin
        due_head = rsp_due.pop_front();
        if (rsp.status !== due_head.status || rsp.byte_out !== due_head.byte_out ||
            rsp.length !== due_head.length || rsp.last !== due_head.last) begin
          errors++;
          $display("%0t: mismatch: expected status %0d byte %02h length %0d last %0d, %s",
                   $time, due_head.status, due_head.byte_out, due_head.length,
                   due_head.last, "see actual below");
          $display("%0t:           actual status %0d byte %02h length %0d last %0d",
                   $time, rsp.status, rsp.byte_out, rsp.length, rsp.last);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int p, cnt;
    int unsigned n;
    req_valid = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SLOT_COUNT;
    cfg_data  = '0;
    wr_idx    = 0;
    rd_idx    = 0;
    used      = 0;
    asm_cnt   = 0;
    overlong  = 1'b0;
    cfg_slots = RST_SLOT_COUNT;
    cfg_max   = RST_MAX_BYTES;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) push_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // fill every slot, overflow once, then drain behind a long receiver hold
    while (used < ring_slots()) send_packet(1);
    send_packet($urandom_range(1, 3));
    rx_hold_req = 1'b1;
    while (used != 0) begin
      if ($urandom_range(0, 7) == 0)
        push_req(mk_req(KIND_QUERY, 8'($urandom), 1'($urandom), 7'($urandom)),
                 1'b0, NOT_TYPED);
      push_req(mk_req(KIND_RECV, 8'($urandom), 1'($urandom), pick_buflen()),
               1'b0, NOT_TYPED);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      set_cfg(ph_slots[p], ph_max[p]);
      send_packet((ring_max() == 0) ? 1 : ring_max());
      if (ring_max() != 0) send_packet(ring_max() + 1);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            n = pick_len();
            send_packet(n);
            cnt += n;
          end
          4, 5, 6: begin
            push_req(mk_req(KIND_RECV, 8'($urandom), 1'($urandom), pick_buflen()),
                     1'b0, NOT_TYPED);
            cnt++;
          end
          7: begin
            push_req(mk_req(KIND_QUERY, 8'($urandom), 1'($urandom), 7'($urandom)),
                     1'b0, NOT_TYPED);
            cnt++;
          end
          8: begin
            // fragment with no last byte; it merges into the next packet
            push_req(mk_req(KIND_SEND, 8'($urandom), 1'b0, 7'($urandom)),
                     1'b0, NOT_TYPED);
            cnt++;
          end
          default: begin
            push_req(mk_req(KIND_UNUSED, 8'($urandom), 1'($urandom), 7'($urandom)),
                     1'b0, NOT_TYPED);
          end
        endcase
      end
      // drain what is queued before the last phase ends
      if (p == NUM_PHASES - 1) begin
        while (used != 0)
          push_req(mk_req(KIND_RECV, 8'($urandom), 1'($urandom), 7'd64), 1'b0, NOT_TYPED);
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/prq_front.sv
rtl/prq_back.sv
rtl/packet_ring_queue.sv
bench/tb_packet_ring_queue.sv
